/* rtl/api_frame_deframer_checksum_unit_macros.svh */
// Assertion macros for the API frame deframer.
`ifndef API_FRAME_DEFRAMER_CHECKSUM_UNIT_MACROS_SVH
`define API_FRAME_DEFRAMER_CHECKSUM_UNIT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define AFDC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer assertion failed");
// next-cycle implication
`define AFDC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer assertion failed");
`else
`define AFDC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define AFDC_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* rtl/afdc_pkg.sv */
package afdc_pkg;

   typedef enum logic [4:0] {
      PH_HUNT   = 5'b00001,
      PH_LEN_HI = 5'b00010,
      PH_LEN_LO = 5'b00100,
      PH_DATA   = 5'b01000,
      PH_CHECK  = 5'b10000
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_GOOD  = 2'd1,
      KIND_BAD   = 2'd2,
      KIND_EMPTY = 2'd3
   } kind_type;

   localparam logic [7:0] START_DELIM = 8'h7E;
   localparam logic [7:0] SUM_GOOD    = 8'hFF;

endpackage

/* rtl/api_frame_deframer_checksum_unit.sv */
// API frame deframer with receive checksum check.
// req_ channel: one received serial byte per item (req_rx_byte), valid/ready.
// rsp_ channel: at most one result item per input byte: a frame data byte
//   with its index, a frame end (checksum good or bad, carrying the received
//   checksum byte), or a zero-length frame notice. Every item carries the
//   frame's length field.
// Bytes before a 0x7E delimiter are dropped one at a time; the two length
// bytes (high first) and a good/bad checksum byte close a frame.
// Latency: a result item appears on rsp_ the cycle after its byte is taken.
// Throughput: one byte per cycle; the parser state and the output register
// both update in the accept cycle, so nothing but the output register
// paces the input.
// Stall: req_ready is high while the output register is empty or being
// drained this cycle; a held result blocks only bytes that arrive after it.
// Reset: synchronous, active high; parser hunts for the delimiter, length,
// count and sum clear, and the output register is emptied.
module api_frame_deframer_checksum_unit
   import afdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data,
   output logic [15:0] rsp_byte_index,
   output logic [15:0] rsp_frame_length
);

`include "api_frame_deframer_checksum_unit_macros.svh"

   phase_type   phase_ff, phase_in;
   logic [15:0] length_reg_ff, length_reg_in;
   logic [15:0] byte_count_ff, byte_count_in;
   logic [7:0]  running_sum_ff, running_sum_in;

   logic        rsp_valid_ff, rsp_valid_in;
   kind_type    rsp_kind_ff, rsp_kind_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;
   logic [15:0] rsp_index_ff, rsp_index_in;
   logic [15:0] rsp_flen_ff, rsp_flen_in;

   logic        accept;
   logic        emit;
   logic [15:0] count_next;
   logic [15:0] length_full;
   logic [7:0]  sum_total;

   // Output register frees up in the same cycle it is drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign count_next  = byte_count_ff + 16'd1;
   assign length_full = {length_reg_ff[15:8], req_rx_byte};
   assign sum_total   = running_sum_ff + req_rx_byte;

   always_comb begin
      phase_in       = phase_ff;
      length_reg_in  = length_reg_ff;
      byte_count_in  = byte_count_ff;
      running_sum_in = running_sum_ff;
      emit           = 1'b0;
      rsp_kind_in    = rsp_kind_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_flen_in    = rsp_flen_ff;
      if (accept) begin
         case (phase_ff)
            PH_LEN_HI: begin
               length_reg_in = {req_rx_byte, 8'h00};
               phase_in      = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               length_reg_in  = length_full;
               byte_count_in  = 16'd0;
               running_sum_in = 8'd0;
               if (length_full == 16'd0) begin
                  // empty frame: report and go back to hunting
                  phase_in     = PH_HUNT;
                  emit         = 1'b1;
                  rsp_kind_in  = KIND_EMPTY;
                  rsp_data_in  = 8'd0;
                  rsp_index_in = 16'd0;
                  rsp_flen_in  = 16'd0;
               end else begin
                  phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               emit           = 1'b1;
               rsp_kind_in    = KIND_DATA;
               rsp_data_in    = req_rx_byte;
               rsp_index_in   = byte_count_ff;
               rsp_flen_in    = length_reg_ff;
               running_sum_in = sum_total;
               byte_count_in  = count_next;
               if (count_next == length_reg_ff) begin
                  phase_in = PH_CHECK;
               end
            end
            PH_CHECK: begin
               emit         = 1'b1;
               rsp_kind_in  = (sum_total == SUM_GOOD) ? KIND_GOOD : KIND_BAD;
               rsp_data_in  = req_rx_byte;
               rsp_index_in = 16'd0;
               rsp_flen_in  = length_reg_ff;
               phase_in     = PH_HUNT;
            end
            default: begin
               // hunting, byte-by-byte resync
               phase_in = (req_rx_byte == START_DELIM) ? PH_LEN_HI : PH_HUNT;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT;
         length_reg_ff  <= 16'd0;
         byte_count_ff  <= 16'd0;
         running_sum_ff <= 8'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         length_reg_ff  <= length_reg_in;
         byte_count_ff  <= byte_count_in;
         running_sum_ff <= running_sum_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff  <= rsp_kind_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_index_ff <= rsp_index_in;
      rsp_flen_ff  <= rsp_flen_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_data         = rsp_data_ff;
   assign rsp_byte_index   = rsp_index_ff;
   assign rsp_frame_length = rsp_flen_ff;

   // data byte accepted -> data item presented next cycle
   `AFDC_ASSERT_NXT(a_data_emits, clock, reset,
      accept && (phase_ff == PH_DATA), rsp_valid_ff && (rsp_kind_ff == KIND_DATA))
   // index stays below the length while in the data phase
   `AFDC_ASSERT_IMP(a_count_in_range, clock, reset,
      phase_ff == PH_DATA, byte_count_ff < length_reg_ff)
   // a stalled input means a result is being held
   `AFDC_ASSERT_IMP(a_stall_cause, clock, reset,
      !req_ready, rsp_valid_ff && !rsp_ready)
   // delimiter while hunting always starts a length read
   `AFDC_ASSERT_NXT(a_hunt_sync, clock, reset,
      accept && (phase_ff == PH_HUNT) && (req_rx_byte == START_DELIM),
      phase_ff == PH_LEN_HI)

endmodule

/* verif/deframer_checker.sv */
module deframer_checker
   import afdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_kind,
   input  logic [7:0]  rsp_data,
   input  logic [15:0] rsp_byte_index,
   input  logic [15:0] rsp_frame_length,
   output int          mismatch_count,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic [15:0] index;
      logic [15:0] flen;
   } frame_item_type;

   frame_item_type expected_items[$];
   phase_type   parse_phase = PH_HUNT;
   logic [15:0] frame_len   = '0;
   logic [15:0] data_count  = '0;
   logic [7:0]  data_sum    = '0;
   int          fault_total = 0;

   task automatic report_mismatch(input string msg);
      $display("%0t deframer mismatch: %s", $time, msg);
      fault_total++;
   endtask

   // Advance the parser by one accepted byte; queue the item it produces.
   task automatic parse_byte(input logic [7:0] b);
      frame_item_type item;
      logic [7:0]  total;
      case (parse_phase)
         PH_LEN_HI: begin
            frame_len   = {b, 8'h00};
            parse_phase = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            frame_len[7:0] = b;
            data_count     = '0;
            data_sum       = '0;
            if (frame_len == 16'd0) begin
               item = '{KIND_EMPTY, 8'h00, 16'd0, 16'd0};
               expected_items.push_back(item);
               parse_phase = PH_HUNT;
            end else begin
               parse_phase = PH_DATA;
            end
         end
         PH_DATA: begin
            item = '{KIND_DATA, b, data_count, frame_len};
            expected_items.push_back(item);
            data_sum   = data_sum + b;
            data_count = data_count + 16'd1;
            if (data_count == frame_len) parse_phase = PH_CHECK;
         end
         PH_CHECK: begin
            total = data_sum + b;
            item  = '{(total == SUM_GOOD) ? KIND_GOOD : KIND_BAD, b, 16'd0, frame_len};
            expected_items.push_back(item);
            parse_phase = PH_HUNT;
         end
         default: begin
            parse_phase = (b == START_DELIM) ? PH_LEN_HI : PH_HUNT;
         end
      endcase
   endtask

   task automatic check_result();
      frame_item_type want;
      if (expected_items.size() == 0) begin
         report_mismatch($sformatf("unexpected item kind=%0d data=%02h index=%0d length=%0d",
                                   rsp_kind, rsp_data, rsp_byte_index, rsp_frame_length));
         return;
      end
      want = expected_items.pop_front();
      if (rsp_kind !== want.kind || rsp_data !== want.data ||
          rsp_byte_index !== want.index || rsp_frame_length !== want.flen)
         report_mismatch($sformatf({"got kind=%0d data=%02h index=%0d length=%0d, ",
                                    "want kind=%0d data=%02h index=%0d length=%0d"},
                                   rsp_kind, rsp_data, rsp_byte_index, rsp_frame_length,
                                   want.kind, want.data, want.index, want.flen));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_items.delete();
         parse_phase = PH_HUNT;
         frame_len   = '0;
         data_count  = '0;
         data_sum    = '0;
      end else begin
         if (req_valid && req_ready) parse_byte(req_rx_byte);
         if (rsp_valid && rsp_ready) check_result();
      end
      outstanding    <= expected_items.size();
      mismatch_count <= fault_total;
   end

endmodule

/* verif/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import afdc_pkg::*;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_data;
   logic [15:0] rsp_byte_index;
   logic [15:0] rsp_frame_length;

   int mismatch_count;
   int outstanding;

   // Idle burst odds in percent, per item on the sender side and per
   // cycle on the receiver side. Both drop to zero for the closing stretch.
   int req_gap_pct = 0;
   int rsp_gap_pct = 0;
   // One-shot request for the receiver to hold off for a long time.
   bit hold_rsp    = 1'b0;

   always #5 clock = ~clock;

   api_frame_deframer_checksum_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_data         (rsp_data),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_frame_length (rsp_frame_length)
   );

   deframer_checker frame_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_data         (rsp_data),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_frame_length (rsp_frame_length),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding)
   );

   // Offer one byte and hold it until the block takes it. Valid stays up
   // into the next call unless an idle burst is drawn here.
   task automatic send_byte(input logic [7:0] b);
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if ($urandom_range(99) < req_gap_pct) begin
         req_valid   <= 1'b0;
         req_rx_byte <= 8'($urandom);
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // Line noise while the parser hunts: anything but the delimiter.
   task automatic send_junk(input int count);
      logic [7:0] b;
      repeat (count) begin
         do b = 8'($urandom); while (b == START_DELIM);
         send_byte(b);
      end
   endtask

   // Data bytes lean toward the delimiter and the all-zero/all-one values,
   // so a delimiter inside a frame shows up often.
   function automatic logic [7:0] pick_data();
      case ($urandom_range(9))
         0, 1:    return START_DELIM;
         2:       return 8'h00;
         3:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // Delimiter, length high/low, data and checksum; an empty frame stops at the
   // length. A bad frame's checksum is pushed off the good value by a nonzero amount.
   task automatic send_frame(input logic [15:0] len, input bit good);
      logic [7:0] data_sum;
      logic [7:0] b;
      logic [7:0] chk;
      data_sum = 8'h00;
      send_byte(START_DELIM);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
      if (len == 16'd0) return;
      for (int i = 0; i < len; i++) begin
         b        = pick_data();
         data_sum = data_sum + b;
         send_byte(b);
      end
      chk = SUM_GOOD - data_sum;
      if (!good) chk = chk + 8'($urandom_range(1, 255));
      send_byte(chk);
   endtask

   // Mostly well-formed short frames with random content, some empty
   // frames, some bad checksums, and noise between frames. Noise bytes are
   // not counted. From quiet_from on, neither side idles.
   task automatic random_frames(input int item_goal, input int quiet_from);
      int sent;
      int len;
      sent = 0;
      while (sent < item_goal) begin
         if (sent >= quiet_from) begin
            req_gap_pct = 0;
            rsp_gap_pct = 0;
         end else if ($urandom_range(15) == 0) begin
            // shuffle the idle mix now and then: none, light or busy
            req_gap_pct = $urandom_range(2) * 15;
            rsp_gap_pct = $urandom_range(2) * 15;
         end
         case ($urandom_range(19))
            0, 1: send_junk($urandom_range(1, 5));
            2: begin
               send_frame(16'd0, 1'b1);
               sent += 3;
            end
            default: begin
               len = $urandom_range(1, 16);
               send_frame(16'(len), $urandom_range(3) != 0);
               sent += len + 4;
            end
         endcase
      end
   endtask

   // Receiver: ready by default, random stall bursts, and the one long
   // hold-off when asked for, counted here in cycles.
   initial begin : rsp_side
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (200) @(posedge clock);
            hold_rsp = 1'b0;
         end else if ($urandom_range(99) < rsp_gap_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   initial begin : stimulus
      // Opening sequence:
      //   noise while hunting (all-zero, all-one, mixed),
      //   empty frame,
      //   one-byte frame whose data byte is the delimiter, good checksum,
      //   one-byte frame whose checksum byte is the delimiter, good,
      //   two-byte frame with extreme data and a bad checksum.
      logic [7:0] opening [22] = '{
         8'h00, 8'hFF, 8'h55,
         8'h7E, 8'h00, 8'h00,
         8'h7E, 8'h00, 8'h01, 8'h7E, 8'h81,
         8'h7E, 8'h00, 8'h01, 8'h81, 8'h7E,
         8'h7E, 8'h00, 8'h02, 8'hFF, 8'h00, 8'h11
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      req_gap_pct = 20;
      rsp_gap_pct = 20;
      foreach (opening[i]) send_byte(opening[i]);

      random_frames(120, 1000);

      // Long receiver hold-off while the sender keeps offering bytes; the
      // output register fills and req_ready must drop.
      hold_rsp = 1'b1;
      random_frames(40, 1000);

      // Larger lengths, nearly without idling to keep the run short:
      // low length byte equal to the delimiter and a nonzero high length byte.
      req_gap_pct = 2;
      rsp_gap_pct = 2;
      send_frame(16'h007E, 1'b1);
      send_frame(16'h0100, 1'b0);

      random_frames(150, 70);

      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      // results show the cycle after their byte is taken; wait out any stragglers
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin : watchdog
      #2ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/afdc_pkg.sv
rtl/api_frame_deframer_checksum_unit.sv
verif/deframer_checker.sv
verif/testbench.sv
